>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl of the response body extractor
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every clock edge outside of reset
`define CHK_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that an antecedent implies a consequent in the same cycle
`define CHK_IMPLY(label, ante, cons, msg) \
  `CHK_CLK(label, (ante) |-> (cons), msg)

`endif

>>> rtl/core/hrbe_pkg.sv
// shared types, codes and constants of the http response body extractor
// no dependencies; imported by hrbe_field_scan and the top level
package hrbe_pkg;

  localparam int HEADER_LIMIT = 1024;
  localparam int COUNT_BITS   = 32;
  localparam int HDR_CNT_W    = $clog2(HEADER_LIMIT + 1);

  // command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_CLOSE = 2'd2;
  localparam logic [1:0] CMD_ABORT = 2'd3;

  // transfer phases, also the status field
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_BODY   = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;
  localparam logic [1:0] PH_FAIL   = 2'd3;

  // progress through cr lf cr lf
  localparam logic [1:0] TP_NONE   = 2'd0;
  localparam logic [1:0] TP_CR     = 2'd1;
  localparam logic [1:0] TP_CRLF   = 2'd2;
  localparam logic [1:0] TP_CRLFCR = 2'd3;

  // field match steps
  localparam int         FIELD_CHARS = 14;
  localparam logic [4:0] STEP_COLON  = 5'd14;
  localparam logic [4:0] STEP_BLANKS = 5'd15;
  localparam logic [4:0] STEP_DIGITS = 5'd16;
  localparam logic [4:0] STEP_IDLE   = 5'd31;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [7:0] FIELD_NAME [FIELD_CHARS] = '{
    8'h63, 8'h6f, 8'h6e, 8'h74, 8'h65, 8'h6e, 8'h74,
    8'h2d, 8'h6c, 8'h65, 8'h6e, 8'h67, 8'h74, 8'h68
  };

  typedef struct packed {
    logic       clear;
    logic       en;
    logic [7:0] data;
  } hrbe_scan_ctl_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] value;
  } hrbe_len_t;

  typedef struct packed {
    hrbe_len_t cur;
    hrbe_len_t nxt;
  } hrbe_scan_sts_t;

endpackage

>>> rtl/core/hrbe_field_scan.sv
// content-length header field matcher and decimal value parser
// depends on hrbe_pkg; driven one header byte at a time by the top level
module hrbe_field_scan (
  input  logic                    clk,
  input  logic                    rst_n,
  input  hrbe_pkg::hrbe_scan_ctl_t ctl,
  output hrbe_pkg::hrbe_scan_sts_t sts
);
  import hrbe_pkg::*;

  logic [4:0]  step_r, step_nxt;
  logic        line_start_r, line_start_nxt;
  logic        decided_r, decided_nxt;
  logic        valid_r, valid_nxt;
  logic [31:0] value_r, value_nxt;

  logic [4:0]  s;
  logic [7:0]  folded;
  logic        is_digit;
  logic [35:0] base;
  logic [35:0] acc;

  always_comb begin
    s        = line_start_r ? 5'd0 : step_r;
    folded   = (ctl.data >= CH_UP_A && ctl.data <= CH_UP_Z) ? ctl.data + CASE_OFS : ctl.data;
    is_digit = ctl.data >= CH_ZERO && ctl.data <= CH_NINE;
    base     = (step_r == STEP_DIGITS) ? {4'd0, value_r} : 36'd0;
    // times ten as two shifts
    acc      = {base[32:0], 3'b000} + {base[34:0], 1'b0} + 36'(ctl.data - CH_ZERO);

    step_nxt       = step_r;
    line_start_nxt = line_start_r;
    decided_nxt    = decided_r;
    valid_nxt      = valid_r;
    value_nxt      = value_r;

    if (ctl.clear) begin
      step_nxt       = 5'd0;
      line_start_nxt = 1'b1;
      decided_nxt    = 1'b0;
      valid_nxt      = 1'b0;
      value_nxt      = 32'd0;
    end else if (ctl.en) begin
      line_start_nxt = ctl.data == CH_LF;
      if (!decided_r) begin
        if (s < 5'(FIELD_CHARS)) begin
          step_nxt = (folded == FIELD_NAME[s[3:0]]) ? s + 5'd1 : STEP_IDLE;
        end else if (s == STEP_COLON && ctl.data == CH_COLON) begin
          decided_nxt = 1'b1;
          step_nxt    = STEP_BLANKS;
        end else begin
          step_nxt = STEP_IDLE;
        end
      end else if (step_r == STEP_BLANKS && (ctl.data == CH_SP || ctl.data == CH_TAB)) begin
        step_nxt = step_r;
      end else if ((step_r == STEP_BLANKS || step_r == STEP_DIGITS) && is_digit) begin
        value_nxt = (acc[35:32] != 4'd0) ? 32'hffff_ffff : acc[31:0];
        valid_nxt = 1'b1;
        step_nxt  = STEP_DIGITS;
      end else begin
        step_nxt = STEP_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= 5'd0;
      line_start_r <= 1'b1;
      decided_r    <= 1'b0;
      valid_r      <= 1'b0;
      value_r      <= 32'd0;
    end else begin
      step_r       <= step_nxt;
      line_start_r <= line_start_nxt;
      decided_r    <= decided_nxt;
      valid_r      <= valid_nxt;
      value_r      <= value_nxt;
    end
  end

  assign sts.cur.valid = valid_r;
  assign sts.cur.value = value_r;
  assign sts.nxt.valid = valid_nxt;
  assign sts.nxt.value = value_nxt;

endmodule

>>> rtl/core/http_response_body_extractor_top.sv
// top level of the http response body extractor: input register, phase and
// counter logic, result register; depends on hrbe_pkg, hrbe_field_scan and
// assert_macros.svh
`include "assert_macros.svh"

// Takes one command per request (start, data byte, close, abort) and returns
// exactly one result per request. The request is captured in the input
// register and its result in the result register, the two around a single
// pass of phase, terminator, content-length and body-count logic; a result
// stall can hold the request in the input register. A new request is taken
// every cycle while the result side keeps up. A stall on the result side
// backs up through the two registers before in_tready drops.
// Header bytes past the limit fail the transfer; body bytes are flagged for
// saving until the parsed content-length is reached or the stream closes or is aborted.
module http_response_body_extractor_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // [7:0] byte_out, [39:8] body_count,
                                  // [40] length_known, [72:41] parsed length, rest zero
  output logic [2:0]  out_tuser   // [0] save_byte, [2:1] status
);
  import hrbe_pkg::*;

  logic                  in_vld_r;
  logic [1:0]            in_cmd_r;
  logic [7:0]            in_byte_r;
  logic                  advance;

  logic [1:0]            phase_r, phase_nxt;
  logic [HDR_CNT_W-1:0]  hdr_r, hdr_nxt;
  logic [1:0]            term_r, term_nxt;
  logic [COUNT_BITS-1:0] saved_r, saved_nxt;
  logic                  save;
  logic                  hdr_full;
  logic                  ended;
  logic [63:0]           saved_wide;

  logic                  out_vld_r;
  logic [79:0]           out_tdata_r;
  logic [2:0]            out_tuser_r;

  hrbe_scan_ctl_t        scan_ctl;
  hrbe_scan_sts_t        scan_sts;

  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cmd_r  <= in_tuser;
      in_byte_r <= in_tdata;
    end
  end

  assign hdr_full = hdr_r >= HDR_CNT_W'(HEADER_LIMIT);

  assign scan_ctl.clear = advance && in_cmd_r == CMD_START;
  assign scan_ctl.en    = advance && in_cmd_r == CMD_DATA && phase_r == PH_HEADER && !hdr_full;
  assign scan_ctl.data  = in_byte_r;

  hrbe_field_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (scan_ctl),
    .sts   (scan_sts)
  );

  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    term_nxt  = term_r;
    saved_nxt = saved_r;
    save      = 1'b0;
    ended     = 1'b0;
    unique case (in_cmd_r)
      CMD_START: begin
        phase_nxt = PH_HEADER;
        hdr_nxt   = '0;
        term_nxt  = TP_NONE;
        saved_nxt = '0;
      end
      CMD_DATA: begin
        if (phase_r == PH_HEADER) begin
          if (hdr_full) begin
            phase_nxt = PH_FAIL;
          end else begin
            hdr_nxt = hdr_r + 1'b1;
            if (in_byte_r == CH_CR) begin
              term_nxt = (term_r == TP_CRLF) ? TP_CRLFCR : TP_CR;
            end else if (in_byte_r == CH_LF) begin
              ended    = term_r == TP_CRLFCR;
              term_nxt = (term_r == TP_CR) ? TP_CRLF : TP_NONE;
            end else begin
              term_nxt = TP_NONE;
            end
            // a terminating lf never changes the parsed length
            if (ended) begin
              phase_nxt = (scan_sts.cur.valid &&
                           64'(saved_r) >= 64'(scan_sts.cur.value)) ? PH_DONE : PH_BODY;
            end
          end
        end else if (phase_r == PH_BODY) begin
          save = 1'b1;
          if (saved_r != '1) begin
            saved_nxt = saved_r + 1'b1;
          end
          if (scan_sts.cur.valid && 64'(saved_nxt) >= 64'(scan_sts.cur.value)) begin
            phase_nxt = PH_DONE;
          end
        end
      end
      CMD_CLOSE: begin
        if (phase_r == PH_HEADER) begin
          phase_nxt = PH_FAIL;
        end else if (phase_r == PH_BODY) begin
          phase_nxt = PH_DONE;
        end
      end
      CMD_ABORT: begin
        if (phase_r == PH_HEADER || phase_r == PH_BODY) begin
          phase_nxt = PH_FAIL;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  assign saved_wide = 64'(saved_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HEADER;
      hdr_r     <= '0;
      term_r    <= TP_NONE;
      saved_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (advance) begin
        phase_r <= phase_nxt;
        hdr_r   <= hdr_nxt;
        term_r  <= term_nxt;
        saved_r <= saved_nxt;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tdata_r[7:0]   <= in_byte_r;
      out_tdata_r[39:8]  <= (saved_wide > 64'h0000_0000_ffff_ffff) ? 32'hffff_ffff
                                                                     : saved_wide[31:0];
      out_tdata_r[40]    <= scan_sts.nxt.valid;
      out_tdata_r[72:41] <= scan_sts.nxt.valid ? scan_sts.nxt.value : 32'd0;
      out_tdata_r[79:73] <= 7'd0;
      out_tuser_r        <= {phase_nxt, save};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `CHK_CLK(a_hdr_bound, hdr_r <= HDR_CNT_W'(HEADER_LIMIT), "header byte count above limit")
  `CHK_IMPLY(a_save_phase, out_vld_r && out_tuser[0],
             out_tuser[2:1] == PH_BODY || out_tuser[2:1] == PH_DONE,
             "body byte flagged outside body")
  `CHK_IMPLY(a_count_len, out_vld_r && out_tdata[40],
             out_tdata[39:8] <= out_tdata[72:41], "body count passed content length")
  `CHK_IMPLY(a_len_flag, out_vld_r && !out_tdata[40], out_tdata[72:41] == 32'd0,
             "length value without known flag")

endmodule

>>> tb/http_response_body_extractor_top_tb.sv
// self-checking testbench for http_response_body_extractor_top: stream driver and
// monitor around a cycle-free model of header parsing and body counting
// depends on hrbe_pkg and the rtl of the top level
module http_response_body_extractor_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hrbe_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_LEN = 60;
  localparam int MODE_ITEMS = 130;
  localparam logic [8*FIELD_CHARS-1:0] CL_NAME = "content-length";
  localparam logic [63:0] SAVED_MAX = (64'd1 << COUNT_BITS) - 64'd1;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
  } wire_req_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic        save;
    logic [1:0]  status;
    logic [31:0] body_count;
    logic        len_known;
    logic [31:0] cl;
  } body_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [2:0]  out_tuser;

  wire_req_t wire_reqs[$];
  body_res_t due_results[$];
  body_res_t want_r;
  int next_idx = 0;
  int acc_cnt = 0;
  int total_reqs = 0;
  int mode_edge1 = 0;
  int mode_edge2 = 0;
  int hold_cnt = 0;
  int cycle_cnt = 0;
  int err_cnt = 0;

  // tracked transfer state
  logic [1:0]  ph;
  int          hdr_cnt;
  logic [1:0]  term;
  logic        at_line_start;
  logic [4:0]  match_step;
  logic        len_decided;
  logic        len_valid;
  logic [31:0] len_value;
  logic [63:0] saved;

  http_response_body_extractor_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #10 clk = ~clk;

  function automatic void clear_tracker();
    ph = PH_HEADER;
    hdr_cnt = 0;
    term = TP_NONE;
    at_line_start = 1'b1;
    match_step = 5'd0;
    len_decided = 1'b0;
    len_valid = 1'b0;
    len_value = '0;
    saved = '0;
  endfunction

  function automatic void scan_length(logic [7:0] b);
    logic [4:0]  s;
    logic [7:0]  f;
    logic [35:0] v;
    if (!len_decided) begin
      s = at_line_start ? 5'd0 : match_step;
      if (s < FIELD_CHARS) begin
        f = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_OFS : b;
        match_step = (f == CL_NAME[8*(FIELD_CHARS-1-s) +: 8]) ? s + 5'd1 : STEP_IDLE;
      end else if (s == STEP_COLON && b == CH_COLON) begin
        len_decided = 1'b1;
        match_step = STEP_BLANKS;
      end else begin
        match_step = STEP_IDLE;
      end
    end else if (!(match_step == STEP_BLANKS && (b == CH_SP || b == CH_TAB))) begin
      if ((match_step == STEP_BLANKS || match_step == STEP_DIGITS) &&
          b >= CH_ZERO && b <= CH_NINE) begin
        v = (match_step == STEP_DIGITS) ? {4'd0, len_value} : 36'd0;
        v = v * 10 + (b - CH_ZERO);
        len_value = (v > 36'hFFFFFFFF) ? 32'hFFFFFFFF : v[31:0];
        len_valid = 1'b1;
        match_step = STEP_DIGITS;
      end else begin
        match_step = STEP_IDLE;
      end
    end
  endfunction

  function automatic logic body_full();
    return len_valid && saved >= {32'd0, len_value};
  endfunction

  // advance the tracked transfer by one request and queue the result it gives
  function automatic void track_response(logic [1:0] cmd, logic [7:0] b);
    body_res_t r;
    logic hdr_end;
    r.save = 1'b0;
    hdr_end = 1'b0;
    case (cmd)
      CMD_START: clear_tracker();
      CMD_DATA: begin
        if (ph == PH_HEADER) begin
          if (hdr_cnt >= HEADER_LIMIT) begin
            ph = PH_FAIL;
          end else begin
            hdr_cnt++;
            scan_length(b);
            at_line_start = (b == CH_LF);
            if (b == CH_CR) begin
              term = (term == TP_CRLF) ? TP_CRLFCR : TP_CR;
            end else if (b == CH_LF) begin
              hdr_end = (term == TP_CRLFCR);
              term = (term == TP_CR) ? TP_CRLF : TP_NONE;
            end else begin
              term = TP_NONE;
            end
            if (hdr_end) ph = body_full() ? PH_DONE : PH_BODY;
          end
        end else if (ph == PH_BODY) begin
          r.save = 1'b1;
          if (saved < SAVED_MAX) saved++;
          if (body_full()) ph = PH_DONE;
        end
      end
      CMD_CLOSE: begin
        if (ph == PH_HEADER) ph = PH_FAIL;
        else if (ph == PH_BODY) ph = PH_DONE;
      end
      default: begin
        if (ph == PH_HEADER || ph == PH_BODY) ph = PH_FAIL;
      end
    endcase
    r.byte_out = b;
    r.status = ph;
    r.body_count = (saved > 64'hFFFFFFFF) ? 32'hFFFFFFFF : saved[31:0];
    r.len_known = len_valid;
    r.cl = len_valid ? len_value : 32'd0;
    due_results.push_back(r);
  endfunction

  function automatic int mode_of(int n);
    return (n < mode_edge1) ? 0 : ((n < mode_edge2) ? 1 : 2);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  task automatic put(logic [1:0] cmd, logic [7:0] b);
    wire_req_t q;
    q.cmd = cmd;
    q.data = b;
    wire_reqs.push_back(q);
  endtask

  task automatic put_text(string s);
    for (int i = 0; i < s.len(); i++) put(CMD_DATA, s[i]);
  endtask

  // content-length line with random case, blanks and value; some are malformed
  task automatic put_length_line(output int want_len);
    logic [7:0] c;
    int kind;
    want_len = -1;
    for (int i = 0; i < FIELD_CHARS; i++) begin
      c = CL_NAME[8*(FIELD_CHARS-1-i) +: 8];
      if (c >= "a" && c <= "z" && $urandom_range(1, 0)) c = c - CASE_OFS;
      if ($urandom_range(15, 0) == 0) c = 8'($urandom_range(255, 0));
      put(CMD_DATA, c);
    end
    put(CMD_DATA, ($urandom_range(9, 0) != 0) ? CH_COLON : 8'($urandom_range(126, 32)));
    repeat ($urandom_range(2, 0)) put(CMD_DATA, $urandom_range(1, 0) ? CH_SP : CH_TAB);
    kind = $urandom_range(9, 0);
    if (kind == 0) begin
      // no digit after the blanks
      put(CMD_DATA, "x");
    end else if (kind < 3) begin
      // long enough that it can saturate
      put(CMD_DATA, 8'($urandom_range(57, 49)));
      repeat (9 + $urandom_range(2, 0)) put(CMD_DATA, 8'($urandom_range(57, 48)));
    end else begin
      want_len = $urandom_range(12, 0);
      if ($urandom_range(3, 0) == 0) put(CMD_DATA, CH_ZERO);
      put_text($sformatf("%0d", want_len));
    end
    if ($urandom_range(3, 0) == 0) put(CMD_DATA, 8'($urandom_range(126, 32)));
    put_text("\r\n");
  endtask

  task automatic put_response();
    int want_len;
    int dup_len;
    int body_n;
    if ($urandom_range(7, 0) == 0) put(2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)));
    put(CMD_START, 8'($urandom_range(255, 0)));
    if ($urandom_range(3, 0) != 0) put_text("HTTP/1.0 200\r\n");
    want_len = -1;
    repeat ($urandom_range(2, 0)) begin
      repeat ($urandom_range(6, 1))
        put(CMD_DATA, ($urandom_range(9, 0) == 0) ? 8'($urandom_range(255, 0))
                                                  : 8'($urandom_range(126, 32)));
      put_text("\r\n");
    end
    if ($urandom_range(3, 0) != 0) put_length_line(want_len);
    if ($urandom_range(3, 0) == 0) put_length_line(dup_len);
    if ($urandom_range(7, 0) == 0) begin
      // header cut short
      put($urandom_range(1, 0) ? CMD_CLOSE : CMD_ABORT, 8'($urandom_range(255, 0)));
      return;
    end
    put_text("\r\n");
    body_n = (want_len >= 0 && $urandom_range(3, 0) != 0) ? want_len + $urandom_range(2, 0)
                                                          : $urandom_range(14, 0);
    repeat (body_n) begin
      if ($urandom_range(23, 0) == 0) put(2'($urandom_range(3, 0)), 8'($urandom_range(255, 0)));
      put(CMD_DATA, 8'($urandom_range(255, 0)));
    end
    case ($urandom_range(5, 0))
      0, 1: put(CMD_CLOSE, 8'($urandom_range(255, 0)));
      2: put(CMD_ABORT, 8'($urandom_range(255, 0)));
      default: ;
    endcase
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_response(in_tuser, in_tdata);
        acc_cnt <= acc_cnt + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (next_idx < wire_reqs.size() &&
            $urandom_range(99, 0) >= (mode_of(next_idx) == 0 ? 34 :
                                      mode_of(next_idx) == 1 ? 65 : 0)) begin
          in_tvalid <= 1'b1;
          in_tuser <= wire_reqs[next_idx].cmd;
          in_tdata <= wire_reqs[next_idx].data;
          next_idx++;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        $error("result with no request waiting for it");
        err_cnt++;
      end else begin
        want_r = due_results.pop_front();
        check_field("byte_out", 32'(want_r.byte_out), 32'(out_tdata[7:0]));
        check_field("save_byte", 32'(want_r.save), 32'(out_tuser[0]));
        check_field("status", 32'(want_r.status), 32'(out_tuser[2:1]));
        check_field("body_count", want_r.body_count, out_tdata[39:8]);
        check_field("length_known", 32'(want_r.len_known), 32'(out_tdata[40]));
        check_field("parsed_len", want_r.cl, out_tdata[72:41]);
      end
    end
  end

  // receiver: long back-pressure at the start of the last phase fills the pipeline
  always @(posedge clk) begin
    if (rst_n && mode_of(acc_cnt) == 2 && hold_cnt < HOLD_LEN) begin
      hold_cnt <= hold_cnt + 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(99, 0) >= (mode_of(acc_cnt) == 0 ? 65 :
                                              mode_of(acc_cnt) == 1 ? 34 : 0);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int lim_start;
    clear_tracker();

    // zero length with odd case and blanks, then requests after completion,
    // then a close while still in the header
    put(CMD_START, 8'h00);
    put_text("cOnTeNt-LeNgTh:\t 0\r\n\r\n");
    put(CMD_DATA, 8'hff);
    put(CMD_CLOSE, 8'h5a);
    put(CMD_ABORT, 8'ha5);
    put(CMD_START, 8'hff);
    put(CMD_CLOSE, 8'h00);
    while (wire_reqs.size() < MODE_ITEMS) put_response();
    mode_edge1 = wire_reqs.size();
    while (wire_reqs.size() < mode_edge1 + MODE_ITEMS) put_response();
    mode_edge2 = wire_reqs.size();

    // header of exactly the limit, terminator included, then the body
    put(CMD_START, 8'h00);
    put_text("content-length: 3\r\n");
    repeat (HEADER_LIMIT - 23) put(CMD_DATA, 8'($urandom_range(126, 32)));
    put_text("\r\n\r\n");
    repeat (3) put(CMD_DATA, 8'($urandom_range(255, 0)));
    // two header bytes past the limit
    put(CMD_START, 8'h00);
    repeat (HEADER_LIMIT + 1) put(CMD_DATA, 8'($urandom_range(126, 32)));
    put(CMD_DATA, CH_CR);
    put(CMD_CLOSE, 8'h00);
    lim_start = wire_reqs.size();
    while (wire_reqs.size() < lim_start + MODE_ITEMS) put_response();
    total_reqs = wire_reqs.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (acc_cnt < total_reqs || due_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> http_response_body_extractor_top.f
+incdir+rtl/core
rtl/core/hrbe_pkg.sv
rtl/core/hrbe_field_scan.sv
rtl/core/http_response_body_extractor_top.sv
tb/http_response_body_extractor_top_tb.sv
